### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int MAX_KEY_BYTES = 8;
  localparam int KEY_W         = 8 * MAX_KEY_BYTES;
  localparam int KLEN_W        = 4;
  localparam int POS_W         = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int PERM_DEPTH    = 256;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH = 2'd1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd7;

  typedef enum logic [11:0] {
    S_INIT = 12'b0000_0000_0001,
    K_RD_I = 12'b0000_0000_0010,
    K_RD_J = 12'b0000_0000_0100,
    K_WR_I = 12'b0000_0000_1000,
    K_WR_J = 12'b0000_0001_0000,
    IDLE   = 12'b0000_0010_0000,
    G_RD_J = 12'b0000_0100_0000,
    G_WR_I = 12'b0000_1000_0000,
    G_WR_J = 12'b0001_0000_0000,
    G_RD_K = 12'b0010_0000_0000,
    G_KS   = 12'b0100_0000_0000,
    G_OUT  = 12'b1000_0000_0000
  } state_t;

  // key length clamped to 1..MAX_KEY_BYTES
  function automatic logic [KLEN_W-1:0] eff_len(input logic [KLEN_W-1:0] n);
    logic [KLEN_W-1:0] r;
    r = n;
    if (n == '0) r = KLEN_W'(1);
    else if (n > KLEN_W'(MAX_KEY_BYTES)) r = KLEN_W'(MAX_KEY_BYTES);
    return r;
  endfunction

endpackage

### hdl/rc4_ram.sv
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/rc4_stream_cipher_top.sv
`timescale 1ns / 1ps
// RC4 byte cipher; one input byte gives one output byte, data XOR keystream, so the
// same block encrypts and decrypts. After reset and after every write of key_bytes or
// key_length the block refills its 256-entry permutation RAM and runs the key
// schedule with s_axis_tready low. Each byte then steps through G_RD_J, G_WR_I,
// G_WR_J, G_RD_K and G_KS to the output register in G_OUT, as the permutation RAM
// has a single read port; a new byte is taken only after the last one has been
// loaded there, so an output stall also holds the input. s_axis_tready is also low
// while cfg_valid is high. Write configuration only while no byte is in flight.

`include "assert_macros.svh"

module rc4_stream_cipher_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // data_in
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // data_out
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rc4_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::KEY_W-1:0]        cfg_data
);
  import rc4_pkg::*;

  state_t state, state_next;

  logic [7:0]        idx_i, idx_i_next;
  logic [7:0]        idx_j, idx_j_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [7:0]        sa, sa_next;
  logic [7:0]        sb, sb_next;
  logic [7:0]        din, din_next;
  logic [7:0]        res, res_next;
  logic              out_valid, out_valid_next;
  logic [7:0]        out_data, out_data_next;
  logic [KEY_W-1:0]  key;
  logic [KLEN_W-1:0] klen;

  logic              cfg_hit;
  logic              ram_we;
  logic [7:0]        ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  logic [7:0]        kb;
  logic [KLEN_W-1:0] len;
  logic              in_xfer;

  rc4_ram #(
    .WIDTH(8),
    .DEPTH(PERM_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == IDLE) && !cfg_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign len = eff_len(klen);
  assign kb  = key[{pos, 3'b000} +: 8];

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_BYTES:  cfg_hit = 1'b1;
        CFG_KEY_LENGTH: cfg_hit = 1'b1;
        default:        cfg_hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_next     = state;
    idx_i_next     = idx_i;
    idx_j_next     = idx_j;
    pos_next       = pos;
    sa_next        = sa;
    sb_next        = sb;
    din_next       = din;
    res_next       = res;
    out_valid_next = out_valid && !m_axis_tready;
    out_data_next  = out_data;
    ram_we         = 1'b0;
    ram_waddr      = idx_i;
    ram_wdata      = idx_i;
    ram_raddr      = idx_i;

    unique case (state)
      S_INIT: begin
        ram_we     = 1'b1;
        idx_i_next = idx_i + 8'd1;
        if (idx_i == 8'hFF) begin
          state_next = K_RD_I;
          idx_j_next = '0;
          pos_next   = '0;
        end
      end
      K_RD_I: begin
        state_next = K_RD_J;
      end
      K_RD_J: begin
        sa_next    = ram_rdata;
        idx_j_next = idx_j + ram_rdata + kb;
        ram_raddr  = idx_j_next;
        state_next = K_WR_I;
      end
      K_WR_I: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        state_next = K_WR_J;
      end
      K_WR_J: begin
        ram_we     = 1'b1;
        ram_waddr  = idx_j;
        ram_wdata  = sa;
        idx_i_next = idx_i + 8'd1;
        if (KLEN_W'(pos) == len - KLEN_W'(1)) pos_next = '0;
        else pos_next = pos + POS_W'(1);
        if (idx_i == 8'hFF) begin
          state_next = IDLE;
          idx_j_next = '0;
        end else begin
          state_next = K_RD_I;
        end
      end
      IDLE: begin
        if (in_xfer) begin
          idx_i_next = idx_i + 8'd1;
          ram_raddr  = idx_i_next;
          din_next   = s_axis_tdata;
          state_next = G_RD_J;
        end
      end
      G_RD_J: begin
        sa_next    = ram_rdata;
        idx_j_next = idx_j + ram_rdata;
        ram_raddr  = idx_j_next;
        state_next = G_WR_I;
      end
      G_WR_I: begin
        sb_next    = ram_rdata;
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        state_next = G_WR_J;
      end
      G_WR_J: begin
        ram_we     = 1'b1;
        ram_waddr  = idx_j;
        ram_wdata  = sa;
        state_next = G_RD_K;
      end
      G_RD_K: begin
        ram_raddr  = sa + sb;
        state_next = G_KS;
      end
      G_KS: begin
        res_next   = din ^ ram_rdata;
        state_next = G_OUT;
      end
      G_OUT: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase

    // a key or length write restarts the fill and schedule
    if (cfg_hit) begin
      state_next = S_INIT;
      idx_i_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      idx_i     <= '0;
      idx_j     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
      key       <= '0;
      klen      <= KLEN_RESET;
    end else begin
      state     <= state_next;
      idx_i     <= idx_i_next;
      idx_j     <= idx_j_next;
      pos       <= pos_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_index == CFG_KEY_BYTES) begin
        key <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_KEY_LENGTH) begin
        klen <= cfg_data[KLEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sa       <= sa_next;
    sb       <= sb_next;
    din      <= din_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  `ASSERT_NXT(a_cfg_restart, clk, rst, cfg_hit, state == S_INIT && idx_i == 8'd0)
  `ASSERT_NXT(a_in_starts, clk, rst, in_xfer && !cfg_hit, state == G_RD_J)
  `ASSERT_NXT(a_out_load, clk, rst, state == G_OUT && (!out_valid || m_axis_tready) && !cfg_hit,
              m_axis_tvalid && state == IDLE)
  `ASSERT_NXT(a_sched_end, clk, rst, state == K_WR_J && idx_i == 8'hFF && !cfg_hit,
              state == IDLE && idx_i == 8'd0 && idx_j == 8'd0)

endmodule
